>>> src/itaf_pkg.sv
// Shared types, codes and character helpers for the integer to ASCII formatter.
package itaf_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int CHAR_W              = 7;
   localparam int RADIX_W             = 2;

   // Radix register codes; the unused code formats as hexadecimal
   localparam logic [RADIX_W-1:0] RADIX_BIN   = 2'd0;
   localparam logic [RADIX_W-1:0] RADIX_DEC   = 2'd1;
   localparam logic [RADIX_W-1:0] RADIX_HEX   = 2'd2;
   localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_DEC;

   // ASCII codes
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
   localparam logic [CHAR_W-1:0] CHAR_MINUS   = 7'h2D;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_SIGN,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic conv_step;
      logic emit_sign;
      logic emit_digit;
   } ctrl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic decimal;
      logic negative;
      logic pos_last;
   } dp_stat_type;

   // Map one digit value to its upper-case ASCII character
   function automatic logic [CHAR_W-1:0] digit_to_char(input logic [3:0] digit);
      logic [CHAR_W-1:0] chr;
      if (digit > 4'd9) begin
         chr = CHAR_UPPER_A + {3'b000, digit - 4'd10};
      end else begin
         chr = CHAR_ZERO + {3'b000, digit};
      end
      return chr;
   endfunction

endpackage

>>> src/itaf_dpath.sv
// Datapath: radix register, magnitude, BCD converter, digit shifter and result registers.
module itaf_dpath #(
   parameter int VALUE_WIDTH = itaf_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [VALUE_WIDTH-1:0]              req_value,
   input  logic                                csr_valid,
   input  logic [itaf_pkg::RADIX_W-1:0]        csr_radix_select,
   input  itaf_pkg::ctrl_cmd_type              cmd,
   output itaf_pkg::dp_stat_type               stat,
   output logic                                rsp_strobe,
   output logic [itaf_pkg::CHAR_W-1:0]         rsp_ascii_char,
   output logic                                rsp_last_char
);

   localparam int NDEC      = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int NHEX      = (VALUE_WIDTH + 3) / 4;
   localparam int DIG_W     = 4 * NDEC;
   localparam int POS_W     = $clog2(VALUE_WIDTH + 1);
   localparam int BIN_SHIFT = DIG_W - VALUE_WIDTH;
   localparam int HEX_SHIFT = DIG_W - 4 * NHEX;

   logic [itaf_pkg::RADIX_W-1:0] radix_ff;
   logic [itaf_pkg::RADIX_W-1:0] mode_ff, mode_in;
   logic                         neg_ff, neg_in;
   logic [VALUE_WIDTH-1:0]       bin_ff, bin_in;
   logic [DIG_W-1:0]             dig_ff, dig_in;
   logic [POS_W-1:0]             pos_ff, pos_in;
   logic                         started_ff, started_in;
   logic                         strobe_ff, strobe_in;
   logic [itaf_pkg::CHAR_W-1:0]  char_ff, char_in;
   logic                         last_ff, last_in;

   logic [VALUE_WIDTH-1:0]       mag;
   logic [DIG_W-1:0]             adj;
   logic [3:0]                   top_digit;
   logic                         pos_last;
   logic                         show;

   // Hold the radix register; the user must write it only while idle, the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= itaf_pkg::RADIX_RESET;
      end else if (csr_valid) begin
         radix_ff <= csr_radix_select;
      end
   end

   // Take the magnitude; the most negative value maps onto its own bit pattern
   assign mag = req_value[VALUE_WIDTH-1] ? (~req_value + 1'b1) : req_value;

   // Add three to every BCD digit of five or more before the next shift
   always_comb begin
      for (int i = 0; i < NDEC; i++) begin
         if (dig_ff[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = dig_ff[4*i +: 4] + 4'd3;
         end else begin
            adj[4*i +: 4] = dig_ff[4*i +: 4];
         end
      end
   end

   assign top_digit = (mode_ff == itaf_pkg::RADIX_BIN) ? {3'b000, dig_ff[DIG_W-1]}
                                                       : dig_ff[DIG_W-1 -: 4];
   assign pos_last  = (pos_ff == POS_W'(1));
   assign show      = (top_digit != 4'd0) || started_ff || pos_last;

   assign stat.decimal  = (radix_ff == itaf_pkg::RADIX_DEC);
   assign stat.negative = neg_ff;
   assign stat.pos_last = pos_last;

   // Work out the next datapath contents from the controller's command
   always_comb begin
      mode_in    = mode_ff;
      neg_in     = neg_ff;
      bin_in     = bin_ff;
      dig_in     = dig_ff;
      pos_in     = pos_ff;
      started_in = started_ff;
      if (cmd.load) begin
         mode_in    = radix_ff;
         neg_in     = req_value[VALUE_WIDTH-1];
         bin_in     = mag;
         started_in = 1'b0;
         case (radix_ff)
            itaf_pkg::RADIX_BIN: begin
               dig_in = DIG_W'(mag) << BIN_SHIFT;
               pos_in = POS_W'(VALUE_WIDTH);
            end
            itaf_pkg::RADIX_DEC: begin
               dig_in = '0;
               pos_in = POS_W'(VALUE_WIDTH);
            end
            default: begin
               dig_in = DIG_W'(mag) << HEX_SHIFT;
               pos_in = POS_W'(NHEX);
            end
         endcase
      end else if (cmd.conv_step) begin
         dig_in = {adj[DIG_W-2:0], bin_ff[VALUE_WIDTH-1]};
         bin_in = bin_ff << 1;
         pos_in = pos_last ? POS_W'(NDEC) : pos_ff - 1'b1;
      end else if (cmd.emit_digit) begin
         dig_in = (mode_ff == itaf_pkg::RADIX_BIN) ? (dig_ff << 1) : (dig_ff << 4);
         pos_in = pos_ff - 1'b1;
         if (show) begin
            started_in = 1'b1;
         end
      end
   end

   // Build the next result; drop leading zeros
   always_comb begin
      strobe_in = cmd.emit_sign || (cmd.emit_digit && show);
      char_in   = cmd.emit_sign ? itaf_pkg::CHAR_MINUS : itaf_pkg::digit_to_char(top_digit);
      last_in   = cmd.emit_digit && pos_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      neg_ff     <= neg_in;
      bin_ff     <= bin_in;
      dig_ff     <= dig_in;
      pos_ff     <= pos_in;
      started_ff <= started_in;
      char_ff    <= char_in;
      last_ff    <= last_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_ascii_char = char_ff;
   assign rsp_last_char  = last_ff;

endmodule

>>> src/itaf_ctrl.sv
// Controller: sequences load, BCD conversion, sign and digit output for one request.
module itaf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  itaf_pkg::dp_stat_type  stat,
   output itaf_pkg::ctrl_cmd_type cmd
);

   itaf_pkg::state_type state_ff, state_in;

   // Hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= itaf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Advance the sequence and issue commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         itaf_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = stat.decimal ? itaf_pkg::ST_CONV : itaf_pkg::ST_SIGN;
            end
         end
         itaf_pkg::ST_CONV: begin
            cmd.conv_step = 1'b1;
            if (stat.pos_last) begin
               state_in = itaf_pkg::ST_SIGN;
            end
         end
         itaf_pkg::ST_SIGN: begin
            cmd.emit_sign = stat.negative;
            state_in      = itaf_pkg::ST_EMIT;
         end
         itaf_pkg::ST_EMIT: begin
            cmd.emit_digit = 1'b1;
            if (stat.pos_last) begin
               state_in = itaf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = itaf_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> src/integer_to_ascii_formatter.sv
// Top level of the integer to ASCII formatter.
//
// Usage: raise start with req_value while busy is low; the request is taken
// at that clock edge. The text of the value then leaves on rsp_ascii_char,
// one character per rsp_strobe cycle, most significant digit first, with
// rsp_last_char set on the final character. Negative values open with '-'.
// The receiver cannot stall: each character is shown for one cycle only.
// csr_radix_select (0 binary, 1 decimal, 2 or 3 hexadecimal) is written with
// csr_valid; csr_ready is always high. Write it only while busy is low.
// Sequence per request, W = VALUE_WIDTH: in decimal the value first passes
// one bit per cycle through the BCD converter; a sign cycle follows, and
// then the digit positions are scanned one per cycle: W binary, ceil(W/4)
// hex, the decimal digit count of 2^W - 1 in decimal. busy stays high
// through all of this, and the next request is taken only once the block
// is idle again, so requests cannot overlap.
// A '-' leaves in the cycle after the sign cycle; the first digit is
// registered from the emit state or later, as leading zeros are skipped.
// The last character leaves in the cycle busy falls. Reset clears the
// sequence and sets the radix to decimal; no clearing pass is needed.
module integer_to_ascii_formatter #(
   parameter int VALUE_WIDTH = itaf_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [VALUE_WIDTH-1:0]       req_value,
   output logic                         rsp_strobe,
   output logic [itaf_pkg::CHAR_W-1:0]  rsp_ascii_char,
   output logic                         rsp_last_char,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [itaf_pkg::RADIX_W-1:0] csr_radix_select
);

   itaf_pkg::ctrl_cmd_type cmd;
   itaf_pkg::dp_stat_type  stat;

   // Accept a register write in any cycle
   assign csr_ready = 1'b1;

   itaf_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   itaf_dpath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_value        (req_value),
      .csr_valid        (csr_valid),
      .csr_radix_select (csr_radix_select),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_strobe       (rsp_strobe),
      .rsp_ascii_char   (rsp_ascii_char),
      .rsp_last_char    (rsp_last_char)
   );

endmodule

>>> src/itaf_chk.sv
// Port checker for the integer to ASCII formatter, bound to the top level.
module itaf_chk (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe,
   input logic rsp_last_char
);

   // No character in the cycle after a request is taken
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> !rsp_strobe)
      else $error("character right after request");

   // A character only follows a busy cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("character without work in progress");

   // The final character is followed by a quiet cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_char |=> !rsp_strobe)
      else $error("character after final character");

   // Only the final character may be seen once busy has dropped
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_char |-> busy)
      else $error("text ended without final flag");

endmodule

bind integer_to_ascii_formatter itaf_chk u_itaf_chk (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_strobe    (rsp_strobe),
   .rsp_last_char (rsp_last_char)
);
